[sv/ball_step_and_pair_collision_macros.svh]
// Assertion macros shared by the ball step and pair collision RTL.
`ifndef BALL_STEP_AND_PAIR_COLLISION_MACROS_SVH
`define BALL_STEP_AND_PAIR_COLLISION_MACROS_SVH

// Same-cycle implication, checked out of reset
`define BSPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define BSPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/bspc_pkg.sv]
// Package: widths, codes, types and arithmetic helpers of the ball collision pipeline.
package bspc_pkg;

  localparam int FRAC_BITS = 16;  // fraction bits of positions and radii
  localparam int NB        = 30;  // fraction bits of normals and mass shares

  localparam int VAL_W  = 32;          // position / velocity width
  localparam int RAD_W  = 24;          // radius width
  localparam int DIFF_W = RAD_W + 1;   // combined radius, overlap, clipped deltas
  localparam int MASS_W = 2 * RAD_W;   // radius squared
  localparam int TOT_W  = MASS_W + 1;  // mass sum
  localparam int MAG_W  = 36;          // impulse magnitudes
  localparam int Q_W    = NB + 1;      // Q1.30 quotient incl. the value one

  // Square root: 52-bit radicand, one result bit per stage
  localparam int SQ_IN_W   = 52;
  localparam int SQ_ROOT_W = SQ_IN_W / 2;
  localparam int SQ_REM_W  = SQ_ROOT_W + 2;
  localparam int SQ_N      = SQ_ROOT_W;

  // Fractional divider: one quotient bit per stage
  localparam int DIV_W = TOT_W;
  localparam int DIV_N = Q_W;

  localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << NB;

  localparam logic signed [VAL_W-1:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] S32_MIN = 32'sh80000000;

  // Register reset values
  localparam logic [15:0] STEP_TIME_RST   = 16'd1092;
  localparam logic [11:0] ARENA_W_RST     = 12'd800;
  localparam logic [11:0] ARENA_H_RST     = 12'd450;
  localparam logic [16:0] RESTITUTION_RST = 17'd63570;

  typedef enum logic [1:0] {
    CFG_STEP_TIME   = 2'd0,
    CFG_ARENA_W     = 2'd1,
    CFG_ARENA_H     = 2'd2,
    CFG_RESTITUTION = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OC_NONE    = 2'd0,
    OC_SEP     = 2'd1,
    OC_IMPULSE = 2'd2
  } outcome_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] apx;
    logic signed [VAL_W-1:0] apy;
    logic signed [VAL_W-1:0] avx;
    logic signed [VAL_W-1:0] avy;
    logic signed [VAL_W-1:0] bpx;
    logic signed [VAL_W-1:0] bpy;
    logic signed [VAL_W-1:0] bvx;
    logic signed [VAL_W-1:0] bvy;
  } balls_t;

  // Clamp to the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [39:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 40'(S32_MAX)) r = S32_MAX;
    else if (v < 40'(S32_MIN)) r = S32_MIN;
    else r = v[VAL_W-1:0];
    return r;
  endfunction

  // Negate, most negative value maps to most positive
  function automatic logic signed [VAL_W-1:0] neg_sat(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v == S32_MIN) r = S32_MAX;
    else r = -v;
    return r;
  endfunction

  // round(a * r / 2^NB) for r <= 2^NB
  function automatic logic [MAG_W-1:0] mulq(input logic [MAG_W-1:0] a,
                                            input logic [Q_W-1:0] r);
    logic [67:0] p;
    p = 68'(a) * 68'(r) + (68'(1) << (NB - 1));
    return p[NB+MAG_W-1:NB];
  endfunction

  // base -/+ magnitude, saturated
  function automatic logic signed [VAL_W-1:0] apply_mag(input logic signed [VAL_W-1:0] base,
                                                        input logic sub,
                                                        input logic [MAG_W-1:0] m);
    logic signed [39:0] b;
    logic signed [39:0] mm;
    b  = 40'(base);
    mm = $signed(40'(m));
    return sat32(sub ? b - mm : b + mm);
  endfunction

  // Reverse the velocity when the ball touches or crosses either wall
  function automatic logic signed [VAL_W-1:0] bounce(input logic signed [VAL_W-1:0] pos,
                                                     input logic signed [VAL_W-1:0] vel,
                                                     input logic [RAD_W-1:0] r,
                                                     input logic [11:0] lim);
    logic signed [39:0] pe;
    logic signed [39:0] re;
    logic signed [39:0] le;
    logic signed [VAL_W-1:0] res;
    pe = 40'(pos);
    re = $signed(40'(r));
    le = $signed(40'({lim, FRAC_BITS'(0)}));
    if ((pe - re <= 40'sd0) || (pe + re >= le)) res = neg_sat(vel);
    else res = vel;
    return res;
  endfunction

endpackage

[sv/bspc_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module bspc_sqrt (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [bspc_pkg::SQ_IN_W-1:0]   d2_i,
  output logic [bspc_pkg::SQ_ROOT_W-1:0] root_o
);
  import bspc_pkg::*;

  logic [SQ_IN_W-1:0]   v_q    [SQ_N];
  logic [SQ_REM_W-1:0]  rem_q  [SQ_N];
  logic [SQ_ROOT_W-1:0] root_q [SQ_N];

  for (genvar k = 0; k < SQ_N; k++) begin : g_stage
    logic [SQ_IN_W-1:0]   v_prev;
    logic [SQ_REM_W-1:0]  rem_prev;
    logic [SQ_ROOT_W-1:0] root_prev;
    logic [SQ_REM_W+1:0]  rem_t;
    logic [SQ_REM_W+1:0]  try_t;
    logic                 ge;

    if (k == 0) begin : g_first
      assign v_prev    = d2_i;
      assign rem_prev  = '0;
      assign root_prev = '0;
    end else begin : g_next
      assign v_prev    = v_q[k-1];
      assign rem_prev  = rem_q[k-1];
      assign root_prev = root_q[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rem_t = {rem_prev, v_prev[SQ_IN_W-1 -: 2]};
    assign try_t = (SQ_REM_W + 2)'({root_prev, 2'b01});
    assign ge    = rem_t >= try_t;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k]    <= v_prev << 2;
        rem_q[k]  <= ge ? SQ_REM_W'(rem_t - try_t) : SQ_REM_W'(rem_t);
        root_q[k] <= {root_prev[SQ_ROOT_W-2:0], ge};
      end
    end
  end

  assign root_o = root_q[SQ_N-1];

endmodule

[sv/bspc_div.sv]
// Pipelined restoring divider: floor(num * 2^30 / den) for num <= den.
module bspc_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [bspc_pkg::DIV_W-1:0] num_i,
  input  logic [bspc_pkg::DIV_W-1:0] den_i,
  output logic [bspc_pkg::Q_W-1:0]   quo_o
);
  import bspc_pkg::*;

  logic [DIV_W-1:0] rem_q [DIV_N];
  logic [DIV_W-1:0] den_q [DIV_N];
  logic [Q_W-1:0]   q_q   [DIV_N];

  for (genvar k = 0; k < DIV_N; k++) begin : g_stage
    logic [DIV_W:0]   rem_t;
    logic [DIV_W-1:0] den_prev;
    logic [Q_W-1:0]   q_prev;
    logic             ge;

    // first stage decides the integer bit, later ones shift in one bit each
    if (k == 0) begin : g_first
      assign rem_t    = {1'b0, num_i};
      assign den_prev = den_i;
      assign q_prev   = '0;
    end else begin : g_next
      assign rem_t    = {rem_q[k-1], 1'b0};
      assign den_prev = den_q[k-1];
      assign q_prev   = q_q[k-1];
    end

    assign ge = rem_t >= {1'b0, den_prev};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DIV_W'(rem_t - {1'b0, den_prev}) : DIV_W'(rem_t);
        den_q[k] <= den_prev;
        q_q[k]   <= {q_prev[Q_W-2:0], ge};
      end
    end
  end

  assign quo_o = q_q[DIV_N-1];

endmodule

[sv/ball_step_and_pair_collision.sv]
// Top level: ball advance with wall bounce and two-ball collision response.
// Takes one ball pair per clock and returns one updated pair per clock. Every
// item runs through 66 register stages (3 front stages for deltas, squares and
// the advance step, 26 square-root stages, 31 divider stages for the normal
// and mass shares, 6 multiply/apply stages). out_valid_o comes from the last of
// these stages, the output register. Depth is set by the bit-per-stage square
// root and divider. The whole pipe holds while the output transfer is stalled,
// and the input is stalled in exactly those cycles. Config registers are to be
// written only with the pipe empty; the block does not enforce this. cfg_ready_o
// is always high.
`include "ball_step_and_pair_collision_macros.svh"

module ball_step_and_pair_collision (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [16:0]        cfg_data_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic signed [31:0] a_pos_x_i,
  input  logic signed [31:0] a_pos_y_i,
  input  logic signed [31:0] a_vel_x_i,
  input  logic signed [31:0] a_vel_y_i,
  input  logic [23:0]        a_radius_i,
  input  logic signed [31:0] b_pos_x_i,
  input  logic signed [31:0] b_pos_y_i,
  input  logic signed [31:0] b_vel_x_i,
  input  logic signed [31:0] b_vel_y_i,
  input  logic [23:0]        b_radius_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] new_a_pos_x_o,
  output logic signed [31:0] new_a_pos_y_o,
  output logic signed [31:0] new_a_vel_x_o,
  output logic signed [31:0] new_a_vel_y_o,
  output logic signed [31:0] new_b_pos_x_o,
  output logic signed [31:0] new_b_pos_y_o,
  output logic signed [31:0] new_b_vel_x_o,
  output logic signed [31:0] new_b_vel_y_o,
  output logic [1:0]         outcome_o
);
  import bspc_pkg::*;

  typedef struct packed {
    balls_t            balls;
    logic              hit;
    logic              negx;
    logic              negy;
    logic [DIFF_W-1:0] mind;
    logic [DIFF_W-1:0] adx;
    logic [DIFF_W-1:0] ady;
    logic [MASS_W-1:0] ma;
    logic [MASS_W-1:0] mb;
    logic [TOT_W-1:0]  tot;
  } pre_t;

  typedef struct packed {
    balls_t            balls;
    logic              hit;
    logic              negx;
    logic              negy;
    logic [DIFF_W-1:0] ovl;
  } side_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [15:0] step_time_q;
  logic [11:0] arena_w_q;
  logic [11:0] arena_h_q;
  logic [16:0] restitution_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q   <= STEP_TIME_RST;
      arena_w_q     <= ARENA_W_RST;
      arena_h_q     <= ARENA_H_RST;
      restitution_q <= RESTITUTION_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_STEP_TIME:   step_time_q   <= cfg_data_i[15:0];
        CFG_ARENA_W:     arena_w_q     <= cfg_data_i[11:0];
        CFG_ARENA_H:     arena_h_q     <= cfg_data_i[11:0];
        CFG_RESTITUTION: restitution_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipe advance: everything moves unless the output register is stalled
  logic out_v_q;
  logic adv;

  assign adv        = !(out_v_q && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------------------------------------------------------------------
  // Stage 1: center deltas, contact box test, advance products
  logic signed [32:0] dx_c, dy_c;
  logic [32:0]        adx_c, ady_c;
  logic [DIFF_W-1:0]  mind_c;

  assign dx_c   = 33'(b_pos_x_i) - 33'(a_pos_x_i);
  assign dy_c   = 33'(b_pos_y_i) - 33'(a_pos_y_i);
  assign adx_c  = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
  assign ady_c  = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
  assign mind_c = DIFF_W'(a_radius_i) + DIFF_W'(b_radius_i);

  logic               s1_v_q;
  logic               s1_kind_q;
  balls_t             s1_balls_q;
  logic [RAD_W-1:0]   s1_ra_q, s1_rb_q;
  logic               s1_negx_q, s1_negy_q, s1_near_q;
  logic [DIFF_W-1:0]  s1_adx_q, s1_ady_q, s1_mind_q;
  logic signed [48:0] s1_prx_q, s1_pry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (adv) s1_v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q      <= kind_i;
      s1_balls_q.apx <= a_pos_x_i;
      s1_balls_q.apy <= a_pos_y_i;
      s1_balls_q.avx <= a_vel_x_i;
      s1_balls_q.avy <= a_vel_y_i;
      s1_balls_q.bpx <= b_pos_x_i;
      s1_balls_q.bpy <= b_pos_y_i;
      s1_balls_q.bvx <= b_vel_x_i;
      s1_balls_q.bvy <= b_vel_y_i;
      s1_ra_q        <= a_radius_i;
      s1_rb_q        <= b_radius_i;
      s1_negx_q      <= dx_c[32];
      s1_negy_q      <= dy_c[32];
      s1_adx_q       <= adx_c[DIFF_W-1:0];
      s1_ady_q       <= ady_c[DIFF_W-1:0];
      s1_mind_q      <= mind_c;
      s1_near_q      <= (adx_c < 33'(mind_c)) && (ady_c < 33'(mind_c));
      s1_prx_q       <= 49'(a_vel_x_i) * 49'($signed({1'b0, step_time_q}));
      s1_pry_q       <= 49'(a_vel_y_i) * 49'($signed({1'b0, step_time_q}));
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: squares, masses, advanced position
  logic signed [48:0] rndx_c, rndy_c;
  logic signed [32:0] delx_c, dely_c;
  balls_t             balls2_c;

  assign rndx_c = s1_prx_q + 49'sd32768;
  assign rndy_c = s1_pry_q + 49'sd32768;
  assign delx_c = 33'(rndx_c >>> 16);
  assign dely_c = 33'(rndy_c >>> 16);

  always_comb begin
    balls2_c = s1_balls_q;
    if (!s1_kind_q) begin
      balls2_c.apx = sat32(40'(s1_balls_q.apx) + 40'(delx_c));
      balls2_c.apy = sat32(40'(s1_balls_q.apy) + 40'(dely_c));
    end
  end

  logic                s2_v_q;
  logic                s2_kind_q;
  balls_t              s2_balls_q;
  logic [RAD_W-1:0]    s2_ra_q;
  logic                s2_negx_q, s2_negy_q, s2_near_q;
  logic [DIFF_W-1:0]   s2_adx_q, s2_ady_q, s2_mind_q;
  logic [2*DIFF_W-1:0] s2_sqx_q, s2_sqy_q, s2_msq_q;
  logic [MASS_W-1:0]   s2_ma_q, s2_mb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (adv) s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_kind_q  <= s1_kind_q;
      s2_balls_q <= balls2_c;
      s2_ra_q    <= s1_ra_q;
      s2_negx_q  <= s1_negx_q;
      s2_negy_q  <= s1_negy_q;
      s2_near_q  <= s1_near_q;
      s2_adx_q   <= s1_adx_q;
      s2_ady_q   <= s1_ady_q;
      s2_mind_q  <= s1_mind_q;
      s2_sqx_q   <= (2*DIFF_W)'(s1_adx_q) * (2*DIFF_W)'(s1_adx_q);
      s2_sqy_q   <= (2*DIFF_W)'(s1_ady_q) * (2*DIFF_W)'(s1_ady_q);
      s2_msq_q   <= (2*DIFF_W)'(s1_mind_q) * (2*DIFF_W)'(s1_mind_q);
      s2_ma_q    <= MASS_W'(s1_ra_q) * MASS_W'(s1_ra_q);
      s2_mb_q    <= MASS_W'(s1_rb_q) * MASS_W'(s1_rb_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: squared distance, contact decision, wall bounce
  logic [2*DIFF_W:0] d2_c;
  pre_t              pre3_c;

  assign d2_c = (2*DIFF_W+1)'(s2_sqx_q) + (2*DIFF_W+1)'(s2_sqy_q);

  always_comb begin
    pre3_c.balls = s2_balls_q;
    if (!s2_kind_q) begin
      pre3_c.balls.avx = bounce(s2_balls_q.apx, s2_balls_q.avx, s2_ra_q, arena_w_q);
      pre3_c.balls.avy = bounce(s2_balls_q.apy, s2_balls_q.avy, s2_ra_q, arena_h_q);
    end
    pre3_c.hit  = s2_kind_q && s2_near_q && (d2_c != '0) &&
                  (d2_c < (2*DIFF_W+1)'(s2_msq_q));
    pre3_c.negx = s2_negx_q;
    pre3_c.negy = s2_negy_q;
    pre3_c.mind = s2_mind_q;
    pre3_c.adx  = s2_adx_q;
    pre3_c.ady  = s2_ady_q;
    pre3_c.ma   = s2_ma_q;
    pre3_c.mb   = s2_mb_q;
    pre3_c.tot  = TOT_W'(s2_ma_q) + TOT_W'(s2_mb_q);
  end

  logic              s3_v_q;
  pre_t              s3_q;
  logic [2*DIFF_W:0] s3_d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (adv) s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q    <= pre3_c;
      s3_d2_q <= d2_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root of the squared distance, item data travels alongside
  logic [SQ_ROOT_W-1:0] root;
  logic                 pre_v_q [SQ_N];
  pre_t                 pre_q   [SQ_N];

  bspc_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .d2_i   (SQ_IN_W'(s3_d2_q)),
    .root_o (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQ_N; k++) pre_v_q[k] <= 1'b0;
    end else if (adv) begin
      pre_v_q[0] <= s3_v_q;
      for (int k = 1; k < SQ_N; k++) pre_v_q[k] <= pre_v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pre_q[0] <= s3_q;
      for (int k = 1; k < SQ_N; k++) pre_q[k] <= pre_q[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Normal components and mass shares, four dividers in parallel
  pre_t           pre_end;
  side_t          side0_c;
  logic [Q_W-1:0] fa, fb, nx, ny;

  assign pre_end = pre_q[SQ_N-1];

  always_comb begin
    side0_c.balls = pre_end.balls;
    side0_c.hit   = pre_end.hit;
    side0_c.negx  = pre_end.negx;
    side0_c.negy  = pre_end.negy;
    side0_c.ovl   = DIFF_W'(SQ_ROOT_W'(pre_end.mind) - root);
  end

  bspc_div u_div_fa (
    .clk_i (clk_i), .en_i (adv),
    .num_i (DIV_W'(pre_end.ma)), .den_i (pre_end.tot), .quo_o (fa)
  );

  bspc_div u_div_fb (
    .clk_i (clk_i), .en_i (adv),
    .num_i (DIV_W'(pre_end.mb)), .den_i (pre_end.tot), .quo_o (fb)
  );

  bspc_div u_div_nx (
    .clk_i (clk_i), .en_i (adv),
    .num_i (DIV_W'(pre_end.adx)), .den_i (DIV_W'(root)), .quo_o (nx)
  );

  bspc_div u_div_ny (
    .clk_i (clk_i), .en_i (adv),
    .num_i (DIV_W'(pre_end.ady)), .den_i (DIV_W'(root)), .quo_o (ny)
  );

  logic  side_v_q [DIV_N];
  side_t side_q   [DIV_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_N; k++) side_v_q[k] <= 1'b0;
    end else if (adv) begin
      side_v_q[0] <= pre_v_q[SQ_N-1];
      for (int k = 1; k < DIV_N; k++) side_v_q[k] <= side_v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side0_c;
      for (int k = 1; k < DIV_N; k++) side_q[k] <= side_q[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // E1: overlap shares, relative velocity along the normal
  side_t              side_end;
  logic signed [32:0] rx_c, ry_c;
  logic [32:0]        arx_c, ary_c;

  assign side_end = side_q[DIV_N-1];
  assign rx_c     = 33'(side_end.balls.bvx) - 33'(side_end.balls.avx);
  assign ry_c     = 33'(side_end.balls.bvy) - 33'(side_end.balls.avy);
  assign arx_c    = rx_c[32] ? 33'(-rx_c) : 33'(rx_c);
  assign ary_c    = ry_c[32] ? 33'(-ry_c) : 33'(ry_c);

  logic              e1_v_q;
  side_t             e1_side_q;
  logic [Q_W-1:0]    e1_fa_q, e1_fb_q, e1_nx_q, e1_ny_q;
  logic [DIFF_W-1:0] e1_mfa_q, e1_mfb_q;
  logic [32:0]       e1_tx_q, e1_ty_q;
  logic              e1_txneg_q, e1_tyneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e1_v_q <= 1'b0;
    else if (adv) e1_v_q <= side_v_q[DIV_N-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_side_q  <= side_end;
      e1_fa_q    <= fa;
      e1_fb_q    <= fb;
      e1_nx_q    <= nx;
      e1_ny_q    <= ny;
      e1_mfa_q   <= DIFF_W'(mulq(MAG_W'(side_end.ovl), fa));
      e1_mfb_q   <= DIFF_W'(mulq(MAG_W'(side_end.ovl), fb));
      e1_tx_q    <= 33'(mulq(MAG_W'(arx_c), nx));
      e1_ty_q    <= 33'(mulq(MAG_W'(ary_c), ny));
      e1_txneg_q <= rx_c[32] != side_end.negx;
      e1_tyneg_q <= ry_c[32] != side_end.negy;
    end
  end

  // ---------------------------------------------------------------------------
  // E2: push-apart magnitudes, normal speed
  logic signed [34:0] txs_c, tys_c;

  assign txs_c = e1_txneg_q ? -$signed(35'(e1_tx_q)) : $signed(35'(e1_tx_q));
  assign tys_c = e1_tyneg_q ? -$signed(35'(e1_ty_q)) : $signed(35'(e1_ty_q));

  logic               e2_v_q;
  side_t              e2_side_q;
  logic [Q_W-1:0]     e2_fa_q, e2_fb_q, e2_nx_q, e2_ny_q;
  logic [DIFF_W-1:0]  e2_pax_q, e2_pay_q, e2_pbx_q, e2_pby_q;
  logic signed [34:0] e2_vn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e2_v_q <= 1'b0;
    else if (adv) e2_v_q <= e1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e2_side_q <= e1_side_q;
      e2_fa_q   <= e1_fa_q;
      e2_fb_q   <= e1_fb_q;
      e2_nx_q   <= e1_nx_q;
      e2_ny_q   <= e1_ny_q;
      e2_pax_q  <= DIFF_W'(mulq(MAG_W'(e1_mfb_q), e1_nx_q));
      e2_pay_q  <= DIFF_W'(mulq(MAG_W'(e1_mfb_q), e1_ny_q));
      e2_pbx_q  <= DIFF_W'(mulq(MAG_W'(e1_mfa_q), e1_nx_q));
      e2_pby_q  <= DIFF_W'(mulq(MAG_W'(e1_mfa_q), e1_ny_q));
      e2_vn_q   <= txs_c + tys_c;
    end
  end

  // ---------------------------------------------------------------------------
  // E3: move positions apart, impulse magnitude
  logic               imp_c;
  logic signed [34:0] nvn_c;
  logic [51:0]        jp_c;
  side_t              side3_c;

  assign imp_c = e2_vn_q <= 35'sd0;
  assign nvn_c = imp_c ? -e2_vn_q : 35'sd0;
  assign jp_c  = 52'(nvn_c[33:0]) * 52'(18'd65536 + 18'(restitution_q)) + 52'd32768;

  always_comb begin
    side3_c = e2_side_q;
    if (e2_side_q.hit) begin
      side3_c.balls.apx = apply_mag(e2_side_q.balls.apx, !e2_side_q.negx, MAG_W'(e2_pax_q));
      side3_c.balls.apy = apply_mag(e2_side_q.balls.apy, !e2_side_q.negy, MAG_W'(e2_pay_q));
      side3_c.balls.bpx = apply_mag(e2_side_q.balls.bpx, e2_side_q.negx, MAG_W'(e2_pbx_q));
      side3_c.balls.bpy = apply_mag(e2_side_q.balls.bpy, e2_side_q.negy, MAG_W'(e2_pby_q));
    end
  end

  logic             e3_v_q;
  side_t            e3_side_q;
  logic [Q_W-1:0]   e3_fa_q, e3_fb_q, e3_nx_q, e3_ny_q;
  logic             e3_imp_q;
  logic [MAG_W-1:0] e3_j_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e3_v_q <= 1'b0;
    else if (adv) e3_v_q <= e2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e3_side_q <= side3_c;
      e3_fa_q   <= e2_fa_q;
      e3_fb_q   <= e2_fb_q;
      e3_nx_q   <= e2_nx_q;
      e3_ny_q   <= e2_ny_q;
      e3_imp_q  <= imp_c;
      e3_j_q    <= jp_c[16+MAG_W-1:16];
    end
  end

  // ---------------------------------------------------------------------------
  // E4: impulse split by mass share
  logic             e4_v_q;
  side_t            e4_side_q;
  logic [Q_W-1:0]   e4_nx_q, e4_ny_q;
  logic             e4_imp_q;
  logic [MAG_W-1:0] e4_ja_q, e4_jb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e4_v_q <= 1'b0;
    else if (adv) e4_v_q <= e3_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e4_side_q <= e3_side_q;
      e4_nx_q   <= e3_nx_q;
      e4_ny_q   <= e3_ny_q;
      e4_imp_q  <= e3_imp_q;
      e4_ja_q   <= mulq(e3_j_q, e3_fb_q);
      e4_jb_q   <= mulq(e3_j_q, e3_fa_q);
    end
  end

  // ---------------------------------------------------------------------------
  // E5: impulse along the normal
  logic             e5_v_q;
  side_t            e5_side_q;
  logic             e5_imp_q;
  logic [MAG_W-1:0] e5_vax_q, e5_vay_q, e5_vbx_q, e5_vby_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e5_v_q <= 1'b0;
    else if (adv) e5_v_q <= e4_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e5_side_q <= e4_side_q;
      e5_imp_q  <= e4_imp_q;
      e5_vax_q  <= mulq(e4_ja_q, e4_nx_q);
      e5_vay_q  <= mulq(e4_ja_q, e4_ny_q);
      e5_vbx_q  <= mulq(e4_jb_q, e4_nx_q);
      e5_vby_q  <= mulq(e4_jb_q, e4_ny_q);
    end
  end

  // ---------------------------------------------------------------------------
  // E6: apply velocity change, output register
  balls_t   balls6_c;
  outcome_e outcome6_c;

  always_comb begin
    balls6_c = e5_side_q.balls;
    if (e5_side_q.hit && e5_imp_q) begin
      balls6_c.avx = apply_mag(e5_side_q.balls.avx, !e5_side_q.negx, e5_vax_q);
      balls6_c.avy = apply_mag(e5_side_q.balls.avy, !e5_side_q.negy, e5_vay_q);
      balls6_c.bvx = apply_mag(e5_side_q.balls.bvx, e5_side_q.negx, e5_vbx_q);
      balls6_c.bvy = apply_mag(e5_side_q.balls.bvy, e5_side_q.negy, e5_vby_q);
    end
    if (!e5_side_q.hit) outcome6_c = OC_NONE;
    else if (e5_imp_q) outcome6_c = OC_IMPULSE;
    else outcome6_c = OC_SEP;
  end

  balls_t   out_balls_q;
  outcome_e out_outcome_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= e5_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_balls_q   <= balls6_c;
      out_outcome_q <= outcome6_c;
    end
  end

  assign out_valid_o   = out_v_q;
  assign new_a_pos_x_o = out_balls_q.apx;
  assign new_a_pos_y_o = out_balls_q.apy;
  assign new_a_vel_x_o = out_balls_q.avx;
  assign new_a_vel_y_o = out_balls_q.avy;
  assign new_b_pos_x_o = out_balls_q.bpx;
  assign new_b_pos_y_o = out_balls_q.bpy;
  assign new_b_vel_x_o = out_balls_q.bvx;
  assign new_b_vel_y_o = out_balls_q.bvy;
  assign outcome_o     = out_outcome_q;

  // ---------------------------------------------------------------------------
  // Assertions
  `BSPC_ASSERT_NEXT(a_stall_holds_out, in_stall_o,
    out_valid_o && $stable(new_a_vel_x_o) && $stable(outcome_o),
    "output changed while stalled")
  `BSPC_ASSERT_NOW(a_overlap_nonzero, e1_v_q && e1_side_q.hit, e1_side_q.ovl != '0,
    "contact item reached divider output with zero overlap")
  `BSPC_ASSERT_NOW(a_quotients_in_range, e1_v_q && e1_side_q.hit,
    (e1_nx_q <= Q_ONE) && (e1_ny_q <= Q_ONE) && (e1_fa_q <= Q_ONE) && (e1_fb_q <= Q_ONE),
    "normal or mass share above one, pipeline misaligned")

endmodule

[tb/ball_step_and_pair_collision_tb.sv]
// Testbench for the ball step and pair collision pipeline: predicted pairs vs. DUT results.
`timescale 1ns / 100ps

module ball_step_and_pair_collision_tb;
  import bspc_pkg::*;

  localparam int IdleLimit = 20000;  // cycles without any transfer before giving up
  localparam int PipeDepth = 66;

  typedef struct {
    logic                kind;
    logic signed [31:0]  apx, apy, avx, avy;
    logic [23:0]         ra;
    logic signed [31:0]  bpx, bpy, bvx, bvy;
    logic [23:0]         rb;
  } pair_t;

  typedef struct {
    balls_t   balls;
    outcome_e oc;
  } pair_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [16:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic kind_i;
  logic signed [31:0] a_pos_x_i, a_pos_y_i, a_vel_x_i, a_vel_y_i;
  logic [23:0] a_radius_i;
  logic signed [31:0] b_pos_x_i, b_pos_y_i, b_vel_x_i, b_vel_y_i;
  logic [23:0] b_radius_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [31:0] new_a_pos_x_o, new_a_pos_y_o, new_a_vel_x_o, new_a_vel_y_o;
  logic signed [31:0] new_b_pos_x_o, new_b_pos_y_o, new_b_vel_x_o, new_b_vel_y_o;
  logic [1:0] outcome_o;

  // Local copy of the configuration registers
  longint unsigned dt_q16;
  longint unsigned width_px;
  longint unsigned height_px;
  longint unsigned coeff_e;

  pair_result_t predicted_pairs[$];
  int  err_cnt;
  bit  no_idle;  // long stretch with no gaps and no stalls
  int  quiet_cycles;

  ball_step_and_pair_collision u_top (.*);

  // Clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // ---------------- prediction ----------------
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round(a * r / 2^30)
  function automatic longint unsigned scale_q30(longint unsigned a, longint unsigned r);
    longint unsigned hi, lo;
    hi = a >> NB;
    lo = a & ((64'd1 << NB) - 1);
    return hi * r + ((lo * r + (64'd1 << (NB - 1))) >> NB);
  endfunction

  // floor(num * 2^30 / den), num <= den
  function automatic longint unsigned ratio_q30(longint unsigned num, longint unsigned den);
    longint unsigned q, rem;
    q = 0;
    rem = num;
    if (rem >= den) begin
      q = 1;
      rem -= den;
    end
    for (int i = 0; i < NB; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, one;
    res = 0;
    one = 64'd1 << 62;
    while (one > v) one = one >> 2;
    while (one != 0) begin
      if (v >= res + one) begin
        v -= res + one;
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res;
  endfunction

  function automatic longint nudge(longint base, bit sub, longint unsigned m);
    return clamp32(sub ? base - longint'(m) : base + longint'(m));
  endfunction

  function automatic longint wall_vel(longint pos, longint vel, longint r, longint lim);
    if (pos - r <= 0 || pos + r >= lim) return clamp32(-vel);
    return vel;
  endfunction

  function automatic pair_result_t resolve_pair(pair_t p);
    pair_result_t res;
    longint apx, apy, avx, avy, bpx, bpy, bvx, bvy, ra, rb, dx, dy, rx, ry, tx, ty, vn;
    longint unsigned mind, adx, ady, d2, center_gap, ovl, ma, mb, tot, fa, fb, nx, ny;
    longint unsigned j, ja, jb;
    bit neg_x, neg_y;
    outcome_e oc;
    apx = p.apx; apy = p.apy; avx = p.avx; avy = p.avy;
    bpx = p.bpx; bpy = p.bpy; bvx = p.bvx; bvy = p.bvy;
    ra = longint'({40'd0, p.ra});
    rb = longint'({40'd0, p.rb});
    oc = OC_NONE;
    if (!p.kind) begin
      apx = clamp32(apx + ((avx * longint'(dt_q16) + 32768) >>> 16));
      apy = clamp32(apy + ((avy * longint'(dt_q16) + 32768) >>> 16));
      avx = wall_vel(apx, avx, ra, longint'(width_px << FRAC_BITS));
      avy = wall_vel(apy, avy, ra, longint'(height_px << FRAC_BITS));
    end else begin
      dx = bpx - apx;
      dy = bpy - apy;
      mind = ra + rb;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      if (adx < mind && ady < mind) begin
        d2 = adx * adx + ady * ady;
        if (d2 != 0 && d2 < mind * mind) begin
          center_gap = int_sqrt(d2);
          ovl = mind - center_gap;
          ma = ra * ra;
          mb = rb * rb;
          tot = ma + mb;
          fa = ratio_q30(ma, tot);
          fb = ratio_q30(mb, tot);
          nx = ratio_q30(adx, center_gap);
          ny = ratio_q30(ady, center_gap);
          neg_x = dx < 0;
          neg_y = dy < 0;
          rx = bvx - avx;
          ry = bvy - avy;
          // push apart, each ball by the share of the other's mass
          apx = nudge(apx, !neg_x, scale_q30(scale_q30(ovl, fb), nx));
          apy = nudge(apy, !neg_y, scale_q30(scale_q30(ovl, fb), ny));
          bpx = nudge(bpx, neg_x, scale_q30(scale_q30(ovl, fa), nx));
          bpy = nudge(bpy, neg_y, scale_q30(scale_q30(ovl, fa), ny));
          oc = OC_SEP;
          tx = scale_q30(rx < 0 ? -rx : rx, nx);
          if ((rx < 0) != neg_x) tx = -tx;
          ty = scale_q30(ry < 0 ? -ry : ry, ny);
          if ((ry < 0) != neg_y) ty = -ty;
          vn = tx + ty;
          // approaching: restitution impulse
          if (vn <= 0) begin
            j = (longint'(-vn) * (65536 + coeff_e) + 32768) >> 16;
            ja = scale_q30(j, fb);
            jb = scale_q30(j, fa);
            avx = nudge(avx, !neg_x, scale_q30(ja, nx));
            avy = nudge(avy, !neg_y, scale_q30(ja, ny));
            bvx = nudge(bvx, neg_x, scale_q30(jb, nx));
            bvy = nudge(bvy, neg_y, scale_q30(jb, ny));
            oc = OC_IMPULSE;
          end
        end
      end
    end
    res.balls.apx = apx[31:0]; res.balls.apy = apy[31:0];
    res.balls.avx = avx[31:0]; res.balls.avy = avy[31:0];
    res.balls.bpx = bpx[31:0]; res.balls.bpy = bpy[31:0];
    res.balls.bvx = bvx[31:0]; res.balls.bvy = bvy[31:0];
    res.oc = oc;
    return res;
  endfunction

  // ---------------- result checking ----------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
               $time, name, $signed(want), want, $signed(got), got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    pair_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_pairs.size() == 0) begin
        $display("%0t: result transfer with no pair pending", $time);
        err_cnt++;
      end else begin
        e = predicted_pairs.pop_front();
        check_field("new_a_pos_x", e.balls.apx, new_a_pos_x_o);
        check_field("new_a_pos_y", e.balls.apy, new_a_pos_y_o);
        check_field("new_a_vel_x", e.balls.avx, new_a_vel_x_o);
        check_field("new_a_vel_y", e.balls.avy, new_a_vel_y_o);
        check_field("new_b_pos_x", e.balls.bpx, new_b_pos_x_o);
        check_field("new_b_pos_y", e.balls.bpy, new_b_pos_y_o);
        check_field("new_b_vel_x", e.balls.bvx, new_b_vel_x_o);
        check_field("new_b_vel_y", e.balls.bvy, new_b_vel_y_o);
        check_field("outcome", 32'(e.oc), 32'(outcome_o));
      end
    end
  end

  // Receiver stalls about 27% of cycles
  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(0, 99) < 27);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_valid_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("ball_step_and_pair_collision_tb failed");
      $finish;
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic send_pair(pair_t p);
    if (!no_idle && $urandom_range(0, 99) < 27) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= p.kind;
    a_pos_x_i <= p.apx; a_pos_y_i <= p.apy; a_vel_x_i <= p.avx; a_vel_y_i <= p.avy;
    a_radius_i <= p.ra;
    b_pos_x_i <= p.bpx; b_pos_y_i <= p.bpy; b_vel_x_i <= p.bvx; b_vel_y_i <= p.bvy;
    b_radius_i <= p.rb;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted_pairs.push_back(resolve_pair(p));
  endtask

  // Let the pipe run empty
  task automatic drain();
    in_valid_i <= 1'b0;
    while (predicted_pairs.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [16:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_STEP_TIME:   dt_q16    = val[15:0];
      CFG_ARENA_W:     width_px  = val[11:0];
      CFG_ARENA_H:     height_px = val[11:0];
      CFG_RESTITUTION: coeff_e   = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] st, logic [11:0] w, logic [11:0] h, logic [16:0] e);
    drain();
    write_reg(CFG_STEP_TIME, 17'(st));
    write_reg(CFG_ARENA_W, 17'(w));
    write_reg(CFG_ARENA_H, 17'(h));
    write_reg(CFG_RESTITUTION, e);
  endtask

  function automatic pair_t make_pair(logic kind, int apx, int apy, int avx, int avy,
                                      logic [23:0] ra, int bpx, int bpy, int bvx, int bvy,
                                      logic [23:0] rb);
    pair_t p;
    p.kind = kind;
    p.apx = apx; p.apy = apy; p.avx = avx; p.avy = avy; p.ra = ra;
    p.bpx = bpx; p.bpy = bpy; p.bvx = bvx; p.bvy = bvy; p.rb = rb;
    return p;
  endfunction

  function automatic logic [23:0] rand_radius();
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    return 24'($urandom_range(0, 60 << 16));
  endfunction

  // Overlapping or nearly touching pair with random content
  function automatic pair_t rand_collide();
    pair_t p;
    int s;
    p.kind = 1'b1;
    p.ra = rand_radius();
    p.rb = rand_radius();
    s = int'(p.ra) + int'(p.rb) + 1;
    p.apx = $urandom_range(0, 1000 << 16);
    p.apy = $urandom_range(0, 1000 << 16);
    p.bpx = p.apx + int'($urandom_range(0, 2 * s)) - s;
    p.bpy = p.apy + int'($urandom_range(0, 2 * s)) - s;
    p.avx = int'($urandom_range(0, 1000 << 16)) - (500 << 16);
    p.avy = int'($urandom_range(0, 1000 << 16)) - (500 << 16);
    p.bvx = int'($urandom_range(0, 1000 << 16)) - (500 << 16);
    p.bvy = int'($urandom_range(0, 1000 << 16)) - (500 << 16);
    return p;
  endfunction

  // Ball in or near the arena moving at a sane speed
  function automatic pair_t rand_advance();
    pair_t p;
    p = rand_collide();
    p.kind = 1'b0;
    p.apx = int'($urandom_range(0, 32'((width_px + 20) << 16))) - (10 << 16);
    p.apy = int'($urandom_range(0, 32'((height_px + 20) << 16))) - (10 << 16);
    return p;
  endfunction

  function automatic pair_t rand_noise();
    return make_pair(1'($urandom), $urandom, $urandom, $urandom, $urandom, 24'($urandom),
                     $urandom, $urandom, $urandom, $urandom, 24'($urandom));
  endfunction

  // ---------------- tests ----------------
  localparam int Px = 100 << 16;
  localparam int R10 = 10 << 16;
  localparam int V = 50 << 16;

  task automatic test_directed();
    // advance: inside, walls, extremes of every field
    send_pair(make_pair(1'b0, 400 << 16, 200 << 16, V, -V, R10, 1, 2, 3, 4, 5));
    send_pair(make_pair(1'b0, 5 << 16, 5 << 16, -V, -V, R10, 0, 0, 0, 0, 0));
    send_pair(make_pair(1'b0, 799 << 16, 449 << 16, V, V, R10, 0, 0, 0, 0, 0));
    send_pair(make_pair(1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        24'hffffff, -1, -1, -1, -1, 24'hffffff));
    send_pair(make_pair(1'b0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                        24'h0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0));
    send_pair(make_pair(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // collide: approaching head on
    send_pair(make_pair(1'b1, Px, Px, V, 0, R10, Px + (15 << 16), Px, -V, 0, R10));
    // separating
    send_pair(make_pair(1'b1, Px, Px, -V, 0, R10, Px + (15 << 16), Px, V, 0, R10));
    // zero normal velocity
    send_pair(make_pair(1'b1, Px, Px, V, V, R10, Px + (12 << 16), Px + (5 << 16), V, V, R10));
    // coincident centers
    send_pair(make_pair(1'b1, Px, Px, V, 0, R10, Px, Px, -V, 0, R10));
    // no contact on one axis, then on distance
    send_pair(make_pair(1'b1, Px, Px, V, 0, R10, Px + (20 << 16), Px, -V, 0, R10));
    send_pair(make_pair(1'b1, Px, Px, V, 0, R10, Px + (15 << 16), Px + (15 << 16), -V, 0, R10));
    // zero radii
    send_pair(make_pair(1'b1, Px, Px, V, 0, 0, Px + 1, Px, -V, 0, 0));
    // one massless ball, diagonal
    send_pair(make_pair(1'b1, Px, Px, V, V, 0, Px - (3 << 16), Px - (4 << 16), -V, -V, R10));
    // largest radii, extreme velocities and positions
    send_pair(make_pair(1'b1, 32'h7fff0000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                        24'hffffff, 32'h7ff00000, 32'h80100000, 32'h80000000, 32'h7fffffff,
                        24'hffffff));
    send_pair(make_pair(1'b1, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                        24'hffffff, 32'h80000001, 32'h7ffffff0, 32'h7fffffff, 32'h80000000,
                        24'h000001));
  endtask

  task automatic test_config_extremes();
    // restitution of one, longest step, widest and flattest arena
    set_config(16'hffff, 12'hfff, 12'd1, 17'd65536);
    test_directed();
    for (int i = 0; i < 20; i++) send_pair(i[0] ? rand_collide() : rand_advance());
    // restitution zero, no motion, narrow and tall arena
    set_config(16'd0, 12'd1, 12'hfff, 17'd0);
    for (int i = 0; i < 20; i++) send_pair(i[0] ? rand_collide() : rand_advance());
    send_pair(make_pair(1'b1, Px, Px, V, 0, R10, Px + (15 << 16), Px, -V, 0, R10));
  endtask

  task automatic test_random(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      no_idle = (i >= n / 3) && (i < n / 3 + 60);
      if (i == n / 2) drain();  // sender waits for every result once
      pick = $urandom_range(0, 99);
      if (pick < 55) send_pair(rand_collide());
      else if (pick < 85) send_pair(rand_advance());
      else send_pair(rand_noise());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = CFG_STEP_TIME; cfg_data_i = '0;
    in_valid_i = 1'b0; kind_i = 1'b0;
    a_pos_x_i = '0; a_pos_y_i = '0; a_vel_x_i = '0; a_vel_y_i = '0; a_radius_i = '0;
    b_pos_x_i = '0; b_pos_y_i = '0; b_vel_x_i = '0; b_vel_y_i = '0; b_radius_i = '0;
    out_stall_i = 1'b0;
    no_idle = 1'b0;
    err_cnt = 0;
    quiet_cycles = 0;
    dt_q16 = STEP_TIME_RST; width_px = ARENA_W_RST;
    height_px = ARENA_H_RST; coeff_e = RESTITUTION_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_config_extremes();
    set_config(16'($urandom), 12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
               17'($urandom_range(0, 65536)));
    test_random(150);
    set_config(STEP_TIME_RST, ARENA_W_RST, ARENA_H_RST, RESTITUTION_RST);
    test_random(330);
    drain();

    if (err_cnt == 0) begin
      $display("ball_step_and_pair_collision_tb passed");
    end else begin
      $display("ball_step_and_pair_collision_tb failed");
    end
    $finish;
  end

endmodule
